@@ src/spc_pkg.sv @@
// Shared widths, payload types and constants for the segment pair closest points unit.
package spc_pkg;

  localparam int COORD_W     = 24;
  localparam int FRAC_BITS   = 16;
  localparam int FRAC_W      = FRAC_BITS + 1;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int RAW_W       = 2 * DIFF_W;
  localparam int DOT_W       = RAW_W - FRAC_BITS;
  localparam int WIDE_W      = 2 * DOT_W;
  localparam int DIV_W       = WIDE_W + 4;
  localparam int REM_W       = DIV_W + 1;
  localparam int NPROD_W     = DOT_W + FRAC_W + 1;
  localparam int NEAR_PROD_W = DIFF_W + FRAC_W + 1;
  localparam int NEAR_W      = NEAR_PROD_W - FRAC_BITS + 1;
  localparam int DELTA_W     = NEAR_W + 1;
  localparam int SQ_W        = 2 * DELTA_W;
  localparam int DIST_W      = 2 * COORD_W - FRAC_BITS + 2;
  localparam int THR_W       = 16;

  localparam logic [THR_W-1:0]  THR_RESET = THR_W'(1);
  localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1) << FRAC_BITS;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic [FRAC_W-1:0]         frac_t;
  typedef logic signed [DIV_W-1:0]   div_val_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } spc_in_t;

  typedef struct packed {
    frac_t               fraction_a;
    frac_t               fraction_b;
    coord_t              near_a_x;
    coord_t              near_a_y;
    coord_t              near_b_x;
    coord_t              near_b_y;
    logic [DIST_W-1:0]   dist_squared;
  } spc_out_t;

  // Per-transaction context carried alongside the divider passes
  typedef struct packed {
    coord_t p1x;
    coord_t p1y;
    coord_t p2x;
    coord_t p2y;
    diff_t  d1x;
    diff_t  d1y;
    diff_t  d2x;
    diff_t  d2y;
    dot_t   dd1;
    dot_t   dd2;
    dot_t   rd1;
    dot_t   rd2;
    dot_t   d12;
    logic   short1;
    logic   short2;
    logic   redo;
    frac_t  f1;
    frac_t  f2;
  } spc_ctx_t;

  typedef struct packed {
    logic below;
    logic above;
  } div_side_t;

endpackage

@@ src/segment_pair_closest_points_unit.sv @@
// Top level: closest points between two 2D segments, fully pipelined.
//
// Input channel (in_valid / in_stall / in_data) takes one segment pair per
// transaction: two segments, start and end points, signed Q8.16.
// Output channel (out_valid / out_stall / out_data) returns one result per
// transaction: both fractions (Q1.16), both closest points, and the squared
// distance (Q.16, saturating).
// A new transaction can be accepted every cycle while in_stall is low, so
// throughput is one per clock. The latency is set by three dependent
// 19-stage dividers (one quotient bit per stage) plus the registers between
// them, the dot-product front end and the distance back end.
// The pipeline advances as a whole; when a result sits in the output
// register and out_stall is high, every stage holds and in_stall is raised.
// cfg_wr_en / cfg_wr_data write the degenerate length threshold; write it
// only while no transaction is in flight.
// Synchronous reset empties the pipeline and sets the threshold to 1.
module segment_pair_closest_points_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  spc_pkg::spc_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output spc_pkg::spc_out_t         out_data,
  input  logic                      cfg_wr_en,
  input  logic [spc_pkg::THR_W-1:0] cfg_wr_data
);
  import spc_pkg::*;

  logic en;
  logic [THR_W-1:0] threshold;

  logic      v_f, v_d1, v_d2, v_d3;
  spc_ctx_t  c_f, c_d1, c_d2, c_d3;
  div_val_t  num1, den1;
  frac_t     q1, q2, q3;
  div_side_t side2;

  logic     v6, v7, v8;
  spc_ctx_t c6, c7, c8;
  spc_ctx_t c6_next, c8_next;
  logic signed [NPROD_W-1:0] m6;
  div_val_t num2, den2, num3, den3;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  spc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .threshold (threshold),
    .out_valid (v_f),
    .ctx       (c_f),
    .num       (num1),
    .den       (den1)
  );

  // Fraction on A from the unclamped solution, clamped to [0,1] by the divider
  spc_div u_div1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_f),
    .in_ctx    (c_f),
    .num       (num1),
    .den       (den1),
    .out_valid (v_d1),
    .out_ctx   (c_d1),
    .quot      (q1),
    .side      ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v6 <= v_d1;
      v7 <= v6;
      v8 <= v_d2;
    end
  end

  always_comb begin
    c6_next    = c_d1;
    c6_next.f1 = q1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c6    <= c6_next;
      m6    <= NPROD_W'(c_d1.d12) * NPROD_W'($signed({1'b0, q1}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c7   <= c6;
      num2 <= DIV_W'(m6 >>> FRAC_BITS) + DIV_W'(c6.rd2);
      den2 <= DIV_W'(c6.dd2);
    end
  end

  // Fraction on B for the A fraction found above
  spc_div u_div2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .in_ctx    (c7),
    .num       (num2),
    .den       (den2),
    .out_valid (v_d2),
    .out_ctx   (c_d2),
    .quot      (q2),
    .side      (side2)
  );

  always_comb begin
    c8_next      = c_d2;
    c8_next.f2   = c_d2.short2 ? '0 : q2;
    c8_next.redo = side2.below | side2.above;
  end

  // B clamped at 0 (or B a point) redoes A from -r.dA; clamped at 1 from d12 - r.dA
  always_ff @(posedge clk) begin
    if (en) begin
      c8      <= c8_next;
      den3    <= DIV_W'(c_d2.dd1);
      if (c_d2.short2 || side2.below) begin
        num3 <= -DIV_W'(c_d2.rd1);
      end else begin
        num3 <= DIV_W'(c_d2.d12) - DIV_W'(c_d2.rd1);
      end
    end
  end

  spc_div u_div3 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v8),
    .in_ctx    (c8),
    .num       (num3),
    .den       (den3),
    .out_valid (v_d3),
    .out_ctx   (c_d3),
    .quot      (q3),
    .side      ()
  );

  spc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_d3),
    .in_ctx    (c_d3),
    .q3        (q3),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_frac_a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.fraction_a <= FRAC_ONE)
    else $error("fraction_a above one");

  a_frac_b_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.fraction_b <= FRAC_ONE)
    else $error("fraction_b above one");

  a_side_excl: assert property (@(posedge clk) disable iff (rst)
    v_d2 |-> !(side2.below && side2.above))
    else $error("divider clamped both ways");

  a_below_zero: assert property (@(posedge clk) disable iff (rst)
    (v_d2 && side2.below) |-> (q2 == '0))
    else $error("clamped-below quotient not zero");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v8 && !en) |=> v8 && $stable(num3))
    else $error("redo operands moved during stall");

endmodule

@@ src/spc_front.sv @@
// Front end: segment deltas, dot products, short tests and the first-pass quotient operands.
module spc_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  spc_pkg::spc_in_t         in_data,
  input  logic [spc_pkg::THR_W-1:0] threshold,
  output logic                     out_valid,
  output spc_pkg::spc_ctx_t        ctx,
  output spc_pkg::div_val_t        num,
  output spc_pkg::div_val_t        den
);
  import spc_pkg::*;

  logic v1, v2, v3, v4, v5;
  spc_ctx_t c1, c2, c3, c4, c5;
  spc_ctx_t c1_next, c3_next;
  diff_t rx1, ry1;

  logic signed [RAW_W-1:0] p_d1x, p_d1y, p_d2x, p_d2y;
  logic signed [RAW_W-1:0] p_r1x, p_r1y, p_r2x, p_r2y, p_cx, p_cy;
  logic signed [RAW_W-1:0] raw_dd1, raw_dd2, raw_rd1, raw_rd2, raw_d12;

  logic signed [WIDE_W-1:0] pa, pb, pc, pd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_comb begin
    c1_next     = '0;
    c1_next.p1x = in_data.a_start_x;
    c1_next.p1y = in_data.a_start_y;
    c1_next.p2x = in_data.b_start_x;
    c1_next.p2y = in_data.b_start_y;
    c1_next.d1x = DIFF_W'(in_data.a_end_x) - DIFF_W'(in_data.a_start_x);
    c1_next.d1y = DIFF_W'(in_data.a_end_y) - DIFF_W'(in_data.a_start_y);
    c1_next.d2x = DIFF_W'(in_data.b_end_x) - DIFF_W'(in_data.b_start_x);
    c1_next.d2y = DIFF_W'(in_data.b_end_y) - DIFF_W'(in_data.b_start_y);
  end

  // Stage 1: deltas
  always_ff @(posedge clk) begin
    if (en) begin
      c1     <= c1_next;
      rx1    <= DIFF_W'(in_data.a_start_x) - DIFF_W'(in_data.b_start_x);
      ry1    <= DIFF_W'(in_data.a_start_y) - DIFF_W'(in_data.b_start_y);
    end
  end

  // Stage 2: raw products
  always_ff @(posedge clk) begin
    if (en) begin
      c2    <= c1;
      p_d1x <= RAW_W'(c1.d1x) * RAW_W'(c1.d1x);
      p_d1y <= RAW_W'(c1.d1y) * RAW_W'(c1.d1y);
      p_d2x <= RAW_W'(c1.d2x) * RAW_W'(c1.d2x);
      p_d2y <= RAW_W'(c1.d2y) * RAW_W'(c1.d2y);
      p_r1x <= RAW_W'(rx1) * RAW_W'(c1.d1x);
      p_r1y <= RAW_W'(ry1) * RAW_W'(c1.d1y);
      p_r2x <= RAW_W'(rx1) * RAW_W'(c1.d2x);
      p_r2y <= RAW_W'(ry1) * RAW_W'(c1.d2y);
      p_cx  <= RAW_W'(c1.d1x) * RAW_W'(c1.d2x);
      p_cy  <= RAW_W'(c1.d1y) * RAW_W'(c1.d2y);
    end
  end

  assign raw_dd1 = p_d1x + p_d1y;
  assign raw_dd2 = p_d2x + p_d2y;
  assign raw_rd1 = p_r1x + p_r1y;
  assign raw_rd2 = p_r2x + p_r2y;
  assign raw_d12 = p_cx + p_cy;

  always_comb begin
    c3_next        = c2;
    c3_next.dd1    = DOT_W'(raw_dd1 >>> FRAC_BITS);
    c3_next.dd2    = DOT_W'(raw_dd2 >>> FRAC_BITS);
    c3_next.rd1    = DOT_W'(raw_rd1 >>> FRAC_BITS);
    c3_next.rd2    = DOT_W'(raw_rd2 >>> FRAC_BITS);
    c3_next.d12    = DOT_W'(raw_d12 >>> FRAC_BITS);
    c3_next.short1 = $unsigned(raw_dd1) < RAW_W'(threshold);
    c3_next.short2 = $unsigned(raw_dd2) < RAW_W'(threshold);
  end

  // Stage 3: dot sums, scaling, short tests
  always_ff @(posedge clk) begin
    if (en) begin
      c3 <= c3_next;
    end
  end

  // Stage 4: cross products for the unclamped solution
  always_ff @(posedge clk) begin
    if (en) begin
      c4 <= c3;
      pa <= WIDE_W'(c3.dd1) * WIDE_W'(c3.dd2);
      pb <= WIDE_W'(c3.d12) * WIDE_W'(c3.d12);
      pc <= WIDE_W'(c3.d12) * WIDE_W'(c3.rd2);
      pd <= WIDE_W'(c3.rd1) * WIDE_W'(c3.dd2);
    end
  end

  // Stage 5: numerator and denominator; a zero divisor makes the first pass yield 0
  always_ff @(posedge clk) begin
    if (en) begin
      c5  <= c4;
      num <= DIV_W'(pc) - DIV_W'(pd);
      if (c4.short1 || c4.short2) begin
        den <= '0;
      end else begin
        den <= DIV_W'(pa) - DIV_W'(pb);
      end
    end
  end

  assign out_valid = v5;
  assign ctx       = c5;

endmodule

@@ src/spc_div.sv @@
// Pipelined restoring divider giving a clamped Q1.16 fraction, one quotient bit per stage.
module spc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  spc_pkg::spc_ctx_t  in_ctx,
  input  spc_pkg::div_val_t  num,
  input  spc_pkg::div_val_t  den,
  output logic               out_valid,
  output spc_pkg::spc_ctx_t  out_ctx,
  output spc_pkg::frac_t     quot,
  output spc_pkg::div_side_t side
);
  import spc_pkg::*;

  localparam int STEPS = FRAC_BITS;

  typedef logic [REM_W-1:0] rem_t;

  logic [DIV_W-1:0] n_abs, d_abs;

  logic     va;
  spc_ctx_t ca;
  rem_t     na, da;
  logic     nega, zeroa;

  logic     v_s    [0:STEPS];
  spc_ctx_t c_s    [0:STEPS];
  rem_t     rem_s  [0:STEPS];
  rem_t     d_s    [0:STEPS];
  frac_t    q_s    [0:STEPS];
  logic     neg_s  [0:STEPS];
  logic     zero_s [0:STEPS];
  logic     ovf_s  [0:STEPS];

  rem_t      rem_sh [1:STEPS];
  logic      ge     [1:STEPS];
  frac_t     q_fin;
  div_side_t side_fin;

  assign n_abs = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
  assign d_abs = den[DIV_W-1] ? DIV_W'(-den) : DIV_W'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      for (int k = 0; k <= STEPS; k++) begin
        v_s[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      va     <= in_valid;
      v_s[0] <= va;
      for (int k = 1; k <= STEPS; k++) begin
        v_s[k] <= v_s[k-1];
      end
      out_valid <= v_s[STEPS];
    end
  end

  // Magnitudes, sign and zero test
  always_ff @(posedge clk) begin
    if (en) begin
      ca    <= in_ctx;
      na    <= REM_W'(n_abs);
      da    <= REM_W'(d_abs);
      nega  <= num[DIV_W-1] ^ den[DIV_W-1];
      zeroa <= (num == '0) || (den == '0);
    end
  end

  // Integer bit and range check
  always_ff @(posedge clk) begin
    if (en) begin
      c_s[0]    <= ca;
      d_s[0]    <= da;
      neg_s[0]  <= nega;
      zero_s[0] <= zeroa;
      ovf_s[0]  <= na >= (da << 1);
      if (na >= da) begin
        rem_s[0] <= na - da;
        q_s[0]   <= FRAC_W'(1);
      end else begin
        rem_s[0] <= na;
        q_s[0]   <= '0;
      end
    end
  end

  always_comb begin
    for (int k = 1; k <= STEPS; k++) begin
      rem_sh[k] = rem_s[k-1] << 1;
      ge[k]     = rem_sh[k] >= d_s[k-1];
    end
  end

  // Fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= STEPS; k++) begin
        c_s[k]    <= c_s[k-1];
        d_s[k]    <= d_s[k-1];
        neg_s[k]  <= neg_s[k-1];
        zero_s[k] <= zero_s[k-1];
        ovf_s[k]  <= ovf_s[k-1];
        q_s[k]    <= {q_s[k-1][FRAC_W-2:0], ge[k]};
        rem_s[k]  <= ge[k] ? rem_sh[k] - d_s[k-1] : rem_sh[k];
      end
    end
  end

  // Clamp to [0,1]; a quotient that truncates to zero counts as inside
  always_comb begin
    q_fin    = q_s[STEPS];
    side_fin = '0;
    if (zero_s[STEPS]) begin
      q_fin = '0;
    end else if (ovf_s[STEPS]) begin
      if (neg_s[STEPS]) begin
        q_fin          = '0;
        side_fin.below = 1'b1;
      end else begin
        q_fin          = FRAC_ONE;
        side_fin.above = 1'b1;
      end
    end else if (q_s[STEPS] == '0) begin
      q_fin = '0;
    end else if (neg_s[STEPS]) begin
      q_fin          = '0;
      side_fin.below = 1'b1;
    end else if (q_s[STEPS] > FRAC_ONE) begin
      q_fin          = FRAC_ONE;
      side_fin.above = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctx <= c_s[STEPS];
      quot    <= q_fin;
      side    <= side_fin;
    end
  end

endmodule

@@ src/spc_back.sv @@
// Back end: final fraction pick, closest points, squared distance and the output register.
module spc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  spc_pkg::spc_ctx_t in_ctx,
  input  spc_pkg::frac_t    q3,
  output logic              out_valid,
  output spc_pkg::spc_out_t out_data
);
  import spc_pkg::*;

  logic v9, v10, v11;
  frac_t f1_sel;
  frac_t f1_9, f2_9, f1_10, f2_10, f1_11, f2_11;
  coord_t p1x_9, p1y_9, p2x_9, p2y_9;

  logic signed [NEAR_PROD_W-1:0] ma_x, ma_y, mb_x, mb_y;
  logic signed [NEAR_W-1:0]      na_x, na_y, nb_x, nb_y;
  logic signed [NEAR_W-1:0]      na_x10, na_y10, nb_x10, nb_y10;
  logic signed [DELTA_W-1:0]     dx10, dy10;
  coord_t                        na_x11, na_y11, nb_x11, nb_y11;
  logic signed [SQ_W-1:0]        sq_x, sq_y;

  logic [SQ_W:0]           sq_sum;
  logic [SQ_W-FRAC_BITS:0] dist_full;
  logic [DIST_W-1:0]       dist_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9        <= 1'b0;
      v10       <= 1'b0;
      v11       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v9        <= in_valid;
      v10       <= v9;
      v11       <= v10;
      out_valid <= v11;
    end
  end

  // First fraction is 0 when A is a point, else comes from the redo pass when B was clamped or B is a point
  always_comb begin
    if (in_ctx.short1) begin
      f1_sel = '0;
    end else if (in_ctx.short2 || in_ctx.redo) begin
      f1_sel = q3;
    end else begin
      f1_sel = in_ctx.f1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_9  <= f1_sel;
      f2_9  <= in_ctx.f2;
      p1x_9 <= in_ctx.p1x;
      p1y_9 <= in_ctx.p1y;
      p2x_9 <= in_ctx.p2x;
      p2y_9 <= in_ctx.p2y;
      ma_x  <= NEAR_PROD_W'(in_ctx.d1x) * NEAR_PROD_W'($signed({1'b0, f1_sel}));
      ma_y  <= NEAR_PROD_W'(in_ctx.d1y) * NEAR_PROD_W'($signed({1'b0, f1_sel}));
      mb_x  <= NEAR_PROD_W'(in_ctx.d2x) * NEAR_PROD_W'($signed({1'b0, in_ctx.f2}));
      mb_y  <= NEAR_PROD_W'(in_ctx.d2y) * NEAR_PROD_W'($signed({1'b0, in_ctx.f2}));
    end
  end

  assign na_x = NEAR_W'(p1x_9) + NEAR_W'(ma_x >>> FRAC_BITS);
  assign na_y = NEAR_W'(p1y_9) + NEAR_W'(ma_y >>> FRAC_BITS);
  assign nb_x = NEAR_W'(p2x_9) + NEAR_W'(mb_x >>> FRAC_BITS);
  assign nb_y = NEAR_W'(p2y_9) + NEAR_W'(mb_y >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      f1_10  <= f1_9;
      f2_10  <= f2_9;
      na_x10 <= na_x;
      na_y10 <= na_y;
      nb_x10 <= nb_x;
      nb_y10 <= nb_y;
      dx10   <= DELTA_W'(na_x) - DELTA_W'(nb_x);
      dy10   <= DELTA_W'(na_y) - DELTA_W'(nb_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_11  <= f1_10;
      f2_11  <= f2_10;
      na_x11 <= COORD_W'(na_x10);
      na_y11 <= COORD_W'(na_y10);
      nb_x11 <= COORD_W'(nb_x10);
      nb_y11 <= COORD_W'(nb_y10);
      sq_x   <= SQ_W'(dx10) * SQ_W'(dx10);
      sq_y   <= SQ_W'(dy10) * SQ_W'(dy10);
    end
  end

  assign sq_sum    = {1'b0, $unsigned(sq_x)} + {1'b0, $unsigned(sq_y)};
  assign dist_full = sq_sum[SQ_W:FRAC_BITS];
  assign dist_sat  = (|dist_full[SQ_W-FRAC_BITS:DIST_W]) ? '1 : dist_full[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.fraction_a   <= f1_11;
      out_data.fraction_b   <= f2_11;
      out_data.near_a_x     <= na_x11;
      out_data.near_a_y     <= na_y11;
      out_data.near_b_x     <= nb_x11;
      out_data.near_b_y     <= nb_y11;
      out_data.dist_squared <= dist_sat;
    end
  end

endmodule
